FILE: hw/rtl/swm_pkg.sv
// shared types and constants for the sliding window median block
// controller states, datapath operations and the command/status structs
// no dependencies
`timescale 1ns / 1ps

package swm_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int MED_W          = 33;
    localparam int CFG_W          = 7;
    localparam int MAX_WINDOW_DEF = 64;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OLD,
        ST_RM_RD,
        ST_RM_CMP,
        ST_SL_RD,
        ST_SL_WR,
        ST_INS_RD,
        ST_INS_CMP,
        ST_MED_RD,
        ST_MED_HI,
        ST_MED_SUM
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT_FILL,
        OP_ACCEPT_FULL,
        OP_OLD_LOAD,
        OP_RM_READ,
        OP_IDX_INC,
        OP_SL_READ,
        OP_SL_WRITE,
        OP_INS_START,
        OP_INS_READ,
        OP_INS_SHIFT,
        OP_INS_PUT,
        OP_MED_LO,
        OP_MED_HI,
        OP_MED_WAIT,
        OP_MED_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   cfg_we;
    } cmd_t;

    typedef struct packed {
        logic full;      // window holds as many samples as the clamped window size
        logic last;      // index is at the last entry of the window
        logic idx_zero;
        logic match;     // sorted read data equals the leaving sample
        logic q_gt;      // sorted read data above the new sample
    } status_t;

endpackage

FILE: hw/rtl/swm_ctrl.sv
// controller for the sliding window median block
// steps the datapath through remove, insert and median read; owns the output valid
// depends on swm_pkg
`timescale 1ns / 1ps

module swm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    output logic            sample_ready,
    output logic            median_valid,
    input  logic            median_ready,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  swm_pkg::status_t st,
    output swm_pkg::cmd_t    cmd
);

    swm_pkg::state_t state_reg;
    swm_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = swm_pkg::OP_NONE;
        cmd.cfg_we     = cfg_valid;
        out_valid_next = out_valid_reg && !median_ready;
        unique case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    if (st.full)
                    begin
                        cmd.op     = swm_pkg::OP_ACCEPT_FULL;
                        state_next = swm_pkg::ST_OLD;
                    end
                    else
                    begin
                        cmd.op     = swm_pkg::OP_ACCEPT_FILL;
                        state_next = swm_pkg::ST_INS_RD;
                    end
                end
            end
            swm_pkg::ST_OLD:
            begin
                cmd.op     = swm_pkg::OP_OLD_LOAD;
                state_next = swm_pkg::ST_RM_RD;
            end
            swm_pkg::ST_RM_RD:
            begin
                cmd.op     = swm_pkg::OP_RM_READ;
                state_next = swm_pkg::ST_RM_CMP;
            end
            swm_pkg::ST_RM_CMP:
            begin
                if (st.match)
                begin
                    state_next = swm_pkg::ST_SL_RD;
                end
                else if (st.last)
                begin
                    cmd.op     = swm_pkg::OP_INS_START;
                    state_next = swm_pkg::ST_INS_RD;
                end
                else
                begin
                    cmd.op     = swm_pkg::OP_IDX_INC;
                    state_next = swm_pkg::ST_RM_RD;
                end
            end
            swm_pkg::ST_SL_RD:
            begin
                if (st.last)
                begin
                    cmd.op     = swm_pkg::OP_INS_START;
                    state_next = swm_pkg::ST_INS_RD;
                end
                else
                begin
                    cmd.op     = swm_pkg::OP_SL_READ;
                    state_next = swm_pkg::ST_SL_WR;
                end
            end
            swm_pkg::ST_SL_WR:
            begin
                cmd.op     = swm_pkg::OP_SL_WRITE;
                state_next = swm_pkg::ST_SL_RD;
            end
            swm_pkg::ST_INS_RD:
            begin
                if (st.idx_zero)
                begin
                    cmd.op     = swm_pkg::OP_INS_PUT;
                    state_next = swm_pkg::ST_MED_RD;
                end
                else
                begin
                    cmd.op     = swm_pkg::OP_INS_READ;
                    state_next = swm_pkg::ST_INS_CMP;
                end
            end
            swm_pkg::ST_INS_CMP:
            begin
                if (st.q_gt)
                begin
                    cmd.op     = swm_pkg::OP_INS_SHIFT;
                    state_next = swm_pkg::ST_INS_RD;
                end
                else
                begin
                    cmd.op     = swm_pkg::OP_INS_PUT;
                    state_next = swm_pkg::ST_MED_RD;
                end
            end
            swm_pkg::ST_MED_RD:
            begin
                // still filling: no beat for this sample
                if (!st.full)
                begin
                    state_next = swm_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.op     = swm_pkg::OP_MED_LO;
                    state_next = swm_pkg::ST_MED_HI;
                end
            end
            swm_pkg::ST_MED_HI:
            begin
                cmd.op     = swm_pkg::OP_MED_HI;
                state_next = swm_pkg::ST_MED_SUM;
            end
            swm_pkg::ST_MED_SUM:
            begin
                if (!out_valid_reg || median_ready)
                begin
                    cmd.op         = swm_pkg::OP_MED_OUT;
                    out_valid_next = 1'b1;
                    state_next     = swm_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.op = swm_pkg::OP_MED_WAIT;
                end
            end
            default:
            begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

    assign sample_ready = (state_reg == swm_pkg::ST_IDLE);
    assign median_valid = out_valid_reg;
    assign cfg_ready    = 1'b1;

endmodule

FILE: hw/rtl/swm_datapath.sv
// datapath for the sliding window median block
// arrival ring and sorted store memories, index and fill counters, median adder
// depends on swm_pkg
`timescale 1ns / 1ps

module swm_datapath #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  swm_pkg::cmd_t                     cmd,
    input  logic [swm_pkg::CFG_W-1:0]         window_size,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
    output logic signed [swm_pkg::MED_W-1:0]  median_x2,
    output swm_pkg::status_t                  st
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;
    localparam int SW    = swm_pkg::SAMPLE_W;

    logic [SW-1:0] ring_mem   [MAX_WINDOW];
    logic [SW-1:0] sorted_mem [MAX_WINDOW];

    logic [swm_pkg::CFG_W-1:0] ws_reg;
    logic [CNT_W-1:0]          fill_reg;
    logic [IDX_W-1:0]          ptr_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          idx_next;

    logic signed [SW-1:0]            sample_reg;
    logic signed [SW-1:0]            old_reg;
    logic signed [SW-1:0]            lo_reg;
    logic signed [swm_pkg::MED_W-1:0] med_reg;

    logic signed [SW-1:0] s_q;
    logic [SW-1:0]        r_q;
    logic [IDX_W-1:0]     s_raddr;
    logic                 s_we;
    logic [IDX_W-1:0]     s_waddr;
    logic [SW-1:0]        s_wdata;
    logic                 r_we;
    logic [IDX_W-1:0]     r_waddr;
    logic [SW-1:0]        r_wdata;

    logic [CMP_W-1:0] ws_ext;
    logic [CNT_W-1:0] eff;
    logic [CNT_W-1:0] ptr_inc;
    logic [CNT_W-1:0] lo_idx;
    logic [CNT_W-1:0] hi_idx;
    logic [CNT_W:0]   idx_inc_w;

    // window size clamped to 1..MAX_WINDOW
    always_comb
    begin
        ws_ext = CMP_W'(ws_reg);
        if (ws_reg == '0)
            eff = CNT_W'(1);
        else if (ws_ext > CMP_W'(MAX_WINDOW))
            eff = CNT_W'(MAX_WINDOW);
        else
            eff = ws_ext[CNT_W-1:0];
    end

    assign ptr_inc   = CNT_W'(ptr_reg) + CNT_W'(1);
    assign lo_idx    = (eff - CNT_W'(1)) >> 1;
    assign hi_idx    = eff >> 1;
    assign idx_inc_w = {1'b0, idx_reg} + {{CNT_W{1'b0}}, 1'b1};

    assign st.full     = (fill_reg == eff);
    assign st.last     = (idx_inc_w >= {1'b0, eff});
    assign st.idx_zero = (idx_reg == '0);
    assign st.match    = (s_q == old_reg);
    assign st.q_gt     = (s_q > sample_reg);

    // sorted store and arrival ring port control
    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = idx_reg[IDX_W-1:0];
        s_wdata = s_q;
        r_we    = 1'b0;
        r_waddr = ptr_reg;
        r_wdata = sample_reg;
        case (cmd.op)
            swm_pkg::OP_SL_READ:  s_raddr = idx_inc_w[IDX_W-1:0];
            swm_pkg::OP_INS_READ: s_raddr = idx_reg[IDX_W-1:0] - IDX_W'(1);
            swm_pkg::OP_MED_LO:   s_raddr = lo_idx[IDX_W-1:0];
            swm_pkg::OP_MED_HI,
            swm_pkg::OP_MED_WAIT: s_raddr = hi_idx[IDX_W-1:0];
            default:              s_raddr = idx_reg[IDX_W-1:0];
        endcase
        case (cmd.op)
            swm_pkg::OP_SL_WRITE,
            swm_pkg::OP_INS_SHIFT:
            begin
                s_we = 1'b1;
            end
            swm_pkg::OP_INS_PUT:
            begin
                s_we    = 1'b1;
                s_wdata = sample_reg;
            end
            swm_pkg::OP_ACCEPT_FILL:
            begin
                r_we    = 1'b1;
                r_waddr = fill_reg[IDX_W-1:0];
                r_wdata = sample;
            end
            swm_pkg::OP_OLD_LOAD:
            begin
                r_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            sorted_mem[s_waddr] <= s_wdata;
        s_q <= sorted_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
            ring_mem[r_waddr] <= r_wdata;
        r_q <= ring_mem[ptr_reg];
    end

    always_comb
    begin
        unique case (cmd.op)
            swm_pkg::OP_ACCEPT_FILL: idx_next = fill_reg;
            swm_pkg::OP_OLD_LOAD:    idx_next = '0;
            swm_pkg::OP_IDX_INC,
            swm_pkg::OP_SL_WRITE:    idx_next = idx_inc_w[CNT_W-1:0];
            swm_pkg::OP_INS_START:   idx_next = eff - CNT_W'(1);
            swm_pkg::OP_INS_SHIFT:   idx_next = idx_reg - CNT_W'(1);
            default:                 idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= swm_pkg::WINDOW_RESET;
            fill_reg <= '0;
            ptr_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.cfg_we)
            begin
                // any write restarts the window empty
                ws_reg   <= window_size;
                fill_reg <= '0;
                ptr_reg  <= '0;
            end
            else if (cmd.op == swm_pkg::OP_ACCEPT_FILL)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
                ptr_reg  <= '0;
            end
            else if (cmd.op == swm_pkg::OP_OLD_LOAD)
            begin
                ptr_reg <= (ptr_inc == eff) ? '0 : ptr_inc[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            swm_pkg::OP_ACCEPT_FILL,
            swm_pkg::OP_ACCEPT_FULL: sample_reg <= sample;
            swm_pkg::OP_OLD_LOAD:    old_reg    <= r_q;
            swm_pkg::OP_MED_HI:      lo_reg     <= s_q;
            swm_pkg::OP_MED_OUT:     med_reg    <= {lo_reg[SW-1], lo_reg} + {s_q[SW-1], s_q};
            default:
            begin
            end
        endcase
    end

    assign median_x2 = med_reg;

endmodule

FILE: hw/rtl/sliding_window_median.sv
// top level of the sliding window median block
// joins the controller and the datapath; holds the assertions
// depends on swm_pkg, swm_ctrl, swm_datapath
`timescale 1ns / 1ps

// Running median over the last W signed 32-bit samples, W = window_size clamped to
// 1..MAX_WINDOW (reset value 3). Each result beat carries twice the median as a
// 33-bit two's complement value with one fractional bit; the first W-1 samples after
// reset or any window_size write give no beat, and every later sample gives one.
// A write to window_size restarts the window empty and must come while the block is
// idle. Samples are handled one at a time through a sorted store with one read and
// one write port that is walked one entry at a time: for a full window the leaving
// sample is found and removed by shifting the entries above it down, then the new
// sample is inserted by shifting larger entries up, and the two median entries are
// read and summed. A result still held in the output register can stall a sample.
// A finished result waits in the output register while the next sample is taken.
module sliding_window_median #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
    output logic                                median_valid,
    input  logic                                median_ready,
    output logic signed [swm_pkg::MED_W-1:0]    median_x2,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]           window_size
);

    swm_pkg::cmd_t    cmd;
    swm_pkg::status_t st;

    swm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .median_valid (median_valid),
        .median_ready (median_ready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .st           (st),
        .cmd          (cmd)
    );

    swm_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .window_size (window_size),
        .sample      (sample),
        .median_x2   (median_x2),
        .st          (st)
    );

`ifndef SYNTH
    // one sample in flight: no second beat right behind the first
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample taken while another is in flight");

    // a result only appears while a sample is being worked on
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(median_valid) |-> $past(!sample_ready))
        else $error("result beat without a sample in progress");

    // a window_size write leaves the window empty
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !st.full)
        else $error("window not restarted after window_size write");
`endif

endmodule

FILE: test/sliding_window_median_test.sv
// testbench for the sliding window median block: a queue-fed sample driver, a result
// monitor and a scoreboard of expected twice-median values kept by a sorted-window model
// depends on swm_pkg and sliding_window_median
`timescale 1ns / 1ps

module sliding_window_median_test;

    localparam int DEPTH         = swm_pkg::MAX_WINDOW_DEF;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int HOLD_CYCLES   = 3000;

    logic                                clk;
    logic                                rst_n;
    logic                                sample_valid;
    logic                                sample_ready;
    logic signed [swm_pkg::SAMPLE_W-1:0] sample;
    logic                                median_valid;
    logic                                median_ready;
    logic signed [swm_pkg::MED_W-1:0]    median_x2;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [swm_pkg::CFG_W-1:0]           window_size;

    sliding_window_median dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .median_valid (median_valid),
        .median_ready (median_ready),
        .median_x2    (median_x2),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_size  (window_size)
    );

    // model of the window
    logic signed [swm_pkg::SAMPLE_W-1:0] win_ring   [DEPTH];
    logic signed [swm_pkg::SAMPLE_W-1:0] win_sorted [DEPTH];
    int                                  win_fill;
    int                                  win_oldest;
    logic [swm_pkg::CFG_W-1:0]           win_size_reg;

    logic signed [swm_pkg::SAMPLE_W-1:0] sample_backlog[$];
    logic signed [swm_pkg::MED_W-1:0]    expected_medians[$];

    int sample_accepts;
    int accepts_seen;
    int cfg_accepts;
    bit offer_held;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_len;
    int hold_seq;
    int hold_seen;
    int hold_left;
    int error_count;
    int cycle_count;

    function automatic int clamp_window(input logic [swm_pkg::CFG_W-1:0] v);
        int w;
        w = int'(v);
        if (w < 1) w = 1;
        if (w > DEPTH) w = DEPTH;
        return w;
    endfunction

    task automatic queue_sample(input logic signed [swm_pkg::SAMPLE_W-1:0] v);
        sample_backlog.insert(sample_backlog.size(), v);
    endtask

    task automatic sorted_put(input logic signed [swm_pkg::SAMPLE_W-1:0] v, input int count);
        int i;
        i = count;
        while (i > 0 && win_sorted[i-1] > v)
        begin
            win_sorted[i] = win_sorted[i-1];
            i--;
        end
        win_sorted[i] = v;
    endtask

    task automatic sorted_take(input logic signed [swm_pkg::SAMPLE_W-1:0] v, input int count);
        int i;
        i = 0;
        while (i < count && win_sorted[i] != v) i++;
        if (i < count)
        begin
            while (i + 1 < count)
            begin
                win_sorted[i] = win_sorted[i+1];
                i++;
            end
        end
    endtask

    task automatic window_step(input logic signed [swm_pkg::SAMPLE_W-1:0] s);
        int                               w;
        int                               p;
        logic signed [swm_pkg::MED_W-1:0] lo;
        logic signed [swm_pkg::MED_W-1:0] hi;
        w = clamp_window(win_size_reg);
        if (win_fill < w)
        begin
            win_ring[win_fill] = s;
            sorted_put(s, win_fill);
            win_fill++;
            win_oldest = 0;
            if (win_fill < w) return;
        end
        else
        begin
            p = win_oldest % w;
            sorted_take(win_ring[p], w);
            sorted_put(s, w - 1);
            win_ring[p] = s;
            win_oldest = (p + 1) % w;
        end
        if (w % 2 == 1)
        begin
            lo = swm_pkg::MED_W'(win_sorted[w/2]);
            hi = lo;
        end
        else
        begin
            lo = swm_pkg::MED_W'(win_sorted[w/2 - 1]);
            hi = swm_pkg::MED_W'(win_sorted[w/2]);
        end
        expected_medians.insert(expected_medians.size(), lo + hi);
    endtask

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // acceptance monitor and scoreboard
    always @(posedge clk)
    begin : monitor
        logic signed [swm_pkg::MED_W-1:0] want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                win_size_reg = window_size;
                win_fill     = 0;
                win_oldest   = 0;
                cfg_accepts++;
            end
            if (sample_valid && sample_ready)
            begin
                window_step(sample);
                sample_accepts++;
            end
            if (median_valid && median_ready)
            begin
                if (expected_medians.size() == 0)
                begin
                    if (error_count < 10)
                        $display("median beat with nothing expected: got %0d", median_x2);
                    error_count++;
                end
                else
                begin
                    want = expected_medians.pop_front();
                    if (median_x2 !== want)
                    begin
                        if (error_count < 10)
                            $display("median_x2 mismatch: expected %0d got %0d", want, median_x2);
                        error_count++;
                    end
                end
            end
        end
    end

    // sample driver
    always @(negedge clk)
    begin
        if (offer_held && sample_accepts != accepts_seen) offer_held = 1'b0;
        accepts_seen = sample_accepts;
        if (!offer_held)
        begin
            if (rst_n && sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                sample       <= sample_backlog.pop_front();
                sample_valid <= 1'b1;
                offer_held   = 1'b1;
            end
            else
            begin
                sample_valid <= 1'b0;
                sample       <= $urandom;
            end
        end
    end

    // result receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            median_ready <= 1'b0;
        end
        else
        begin
            median_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic wait_results();
        while (sample_backlog.size() != 0 || offer_held || expected_medians.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [swm_pkg::CFG_W-1:0] v);
        int n0;
        settle();
        n0 = cfg_accepts;
        @(negedge clk);
        cfg_valid   <= 1'b1;
        window_size <= v;
        @(negedge clk);
        while (cfg_accepts == n0) @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [swm_pkg::SAMPLE_W-1:0] pick_sample(
        input logic signed [swm_pkg::SAMPLE_W-1:0] prev
    );
        logic signed [swm_pkg::SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = int'($urandom_range(0, 8)) - 4;   // dense duplicates
            7:          v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            8:          v = $urandom_range(0, 1) ? 32'sh7fffffff - int'($urandom_range(0, 3))
                                                 : 32'sh80000000 + int'($urandom_range(0, 3));
            default:    v = prev + int'($urandom_range(0, 6)) - 3;
        endcase
        return v;
    endfunction

    initial
    begin : stimulus
        int                                  random_sent;
        int                                  phase_no;
        int                                  n_items;
        int                                  k;
        logic [swm_pkg::CFG_W-1:0]           wsel;
        logic signed [swm_pkg::SAMPLE_W-1:0] last_pick;

        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        sample         = '0;
        median_ready   = 1'b0;
        cfg_valid      = 1'b0;
        window_size    = swm_pkg::WINDOW_RESET;
        win_size_reg   = swm_pkg::WINDOW_RESET;
        win_fill       = 0;
        win_oldest     = 0;
        sample_accepts = 0;
        accepts_seen   = 0;
        cfg_accepts    = 0;
        offer_held     = 1'b0;
        send_idle_pct  = 12;
        recv_idle_pct  = 61;
        hold_len       = 0;
        hold_seq       = 0;
        hold_seen      = 0;
        hold_left      = 0;
        error_count    = 0;
        last_pick      = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset window of three: extremes, filling, duplicate removal
        queue_sample(32'sh7fffffff);
        queue_sample(32'sh80000000);
        queue_sample(32'sh00000000);
        queue_sample(32'sh80000000);
        queue_sample(32'sh80000000);
        queue_sample(32'sh7fffffff);
        queue_sample(32'sh7fffffff);
        queue_sample(32'sh7fffffff);

        // even window: most negative and most positive sums
        write_window(7'd2);
        repeat (3) queue_sample(32'sh80000000);
        repeat (3) queue_sample(32'sh7fffffff);

        // zero window acts as one
        write_window(7'd0);
        queue_sample(32'sd5);
        queue_sample(-32'sd1);
        queue_sample(32'sd0);

        // same value again still restarts the window
        write_window(7'd0);
        queue_sample(32'sd42);

        // receiver holds off long enough for the input to back up
        write_window(7'd2);
        hold_len = HOLD_CYCLES;
        hold_seq++;
        for (k = 0; k < 60; k++)
        begin
            last_pick = pick_sample(last_pick);
            queue_sample(last_pick);
        end

        random_sent = 0;
        phase_no    = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 61;
            end
            else if (random_sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (phase_no % 8 == 3)
            begin
                case ((phase_no / 8) % 4)
                    0:       wsel = 7'd127;
                    1:       wsel = 7'd64;
                    2:       wsel = 7'd65;
                    default: wsel = swm_pkg::CFG_W'($urandom_range(66, 126));
                endcase
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       wsel = swm_pkg::CFG_W'($urandom_range(0, 1));
                    1:       wsel = swm_pkg::CFG_W'($urandom_range(13, 40));
                    default: wsel = swm_pkg::CFG_W'($urandom_range(2, 12));
                endcase
            end
            write_window(wsel);

            n_items = clamp_window(wsel) + int'($urandom_range(5, 40));
            for (k = 0; k < n_items; k++)
            begin
                // one pause mid-stream until every result is back
                if (phase_no == 1 && k == n_items / 2) wait_results();
                last_pick = pick_sample(last_pick);
                queue_sample(last_pick);
            end
            random_sent += n_items;
            phase_no++;
        end

        settle();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_ctrl.sv
hw/rtl/swm_datapath.sv
hw/rtl/sliding_window_median.sv
test/sliding_window_median_test.sv
